>>> rtl/blfr_pkg.sv
// blfr_pkg: shared types, constants and helpers for the frame receiver
// depends on nothing; imported by every module of the block except blfr_ram
`default_nettype none

package blfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 6;
    localparam int CFG_IDX_W = 2;

    // fixed frame layout in the store
    localparam int POS_ADDR = 1;
    localparam int POS_LEN  = 2;
    localparam int POS_CMD  = 3;
    localparam int POS_INFO = 4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADDR    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHKSUM  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST = 2'd3;

    // check job handed from the front to the back
    typedef struct packed {
        logic [BYTE_W-1:0] adr;
        logic [BYTE_W-1:0] lenb;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] len;
        logic              bad_len;
    } t_job;

    // 8-bit binary to two bcd digits, valid below 100; above, the high digit is (v/10) mod 16
    // quotient by 10 via reciprocal 205/2048, exact below 1029
    function automatic logic [BYTE_W-1:0] bcd8(input logic [BYTE_W-1:0] v);
        logic [18:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = 19'(v) * 19'd205;
        q    = prod[15:11];
        r    = v - 8'(q) * 8'd10;
        return {q[3:0], r[3:0]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/bcd_length_frame_receiver_top.sv
// bcd_length_frame_receiver_top: serial frame receiver with bcd length and checksum
// depends on blfr_pkg, blfr_ram, blfr_front, blfr_fifo, blfr_back
`default_nettype none

// channel   direction  handshake                    payload
// rx        in         i_in_valid / o_in_ready      i_rx_byte
// result    out        o_out_valid / i_out_ready    o_status .. o_last
// config    in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// a non-tail byte is taken and the next can follow at once, unless a tail still holds the store
// a tail byte holds off further bytes while the frame is checked: the back end
// sums the info bytes in the store, then reads back and emits each info byte,
// all through the single read port of the frame store
// reset is synchronous, active low; no clearing pass, per-entry written
// bits make unwritten store entries read as zero
// a stalled result register holds the back end, and the front waits with it
// until the frame's last result is registered
module bcd_length_frame_receiver_top #(
    parameter int FRAME_BYTES = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // receive byte transfer
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [blfr_pkg::BYTE_W-1:0]        i_rx_byte,
    // result transfer
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [blfr_pkg::STATUS_W-1:0]           o_status,
    output logic [blfr_pkg::BYTE_W-1:0]             o_command,
    output logic [blfr_pkg::BYTE_W-1:0]             o_address,
    output logic [blfr_pkg::BYTE_W-1:0]             o_data_byte,
    output logic                                    o_data_valid,
    output logic [blfr_pkg::IDX_W-1:0]              o_byte_index,
    output logic                                    o_last,
    // register writes
    input  wire logic                               i_cfg_we,
    input  wire logic [blfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [blfr_pkg::BYTE_W-1:0]        i_cfg_data
);
    import blfr_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    // configuration registers
    logic [BYTE_W-1:0] r_head, r_tail, r_host, r_bcast;

    // store write side (front)
    logic              st_we;
    logic [AW-1:0]     st_waddr;
    logic [BYTE_W-1:0] st_wdata;
    logic [FRAME_BYTES-1:0] st_written;

    // store read side (back)
    logic              st_re;
    logic [AW-1:0]     st_raddr;
    logic [BYTE_W-1:0] st_rdata;

    // job queue
    logic q_push, q_ready, q_valid, q_pop;
    t_job q_in, q_out;

    // back end done with the store, front may take bytes again
    logic release_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 8'd126;
            r_tail  <= 8'd13;
            r_host  <= 8'd1;
            r_bcast <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAD:  r_head  <= i_cfg_data;
                CFG_TAIL:  r_tail  <= i_cfg_data;
                CFG_HOST:  r_host  <= i_cfg_data;
                CFG_BCAST: r_bcast <= i_cfg_data;
                default:   r_head  <= r_head;
            endcase
        end
    end

    // frame store
    blfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // byte intake, write position and header capture
    blfr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_head      (r_head),
        .i_tail      (r_tail),
        .o_we        (st_we),
        .o_waddr     (st_waddr),
        .o_wdata     (st_wdata),
        .o_written   (st_written),
        .o_job_valid (q_push),
        .i_job_ready (q_ready),
        .o_job       (q_in),
        .i_release   (release_store)
    );

    blfr_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .i_job   (q_in),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_out)
    );

    // frame check and result emission
    blfr_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .o_job_pop    (q_pop),
        .i_job        (q_out),
        .i_host       (r_host),
        .i_bcast      (r_bcast),
        .o_re         (st_re),
        .o_raddr      (st_raddr),
        .i_rdata      (st_rdata),
        .i_written    (st_written),
        .o_release    (release_store),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_command    (o_command),
        .o_address    (o_address),
        .o_data_byte  (o_data_byte),
        .o_data_valid (o_data_valid),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

>>> rtl/blfr_ram.sv
// blfr_ram: generic single-write, single-read ram with registered read
// depends on nothing
`default_nettype none

module blfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/blfr_front.sv
// blfr_front: takes received bytes, writes the frame store, classifies tails
// depends on blfr_pkg
`default_nettype none

module blfr_front #(
    parameter int FRAME_BYTES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [blfr_pkg::BYTE_W-1:0]      i_rx_byte,
    input  wire logic [blfr_pkg::BYTE_W-1:0]      i_head,
    input  wire logic [blfr_pkg::BYTE_W-1:0]      i_tail,
    output logic                                  o_we,
    output logic [$clog2(FRAME_BYTES)-1:0]        o_waddr,
    output logic [blfr_pkg::BYTE_W-1:0]           o_wdata,
    output logic [FRAME_BYTES-1:0]                o_written,
    output logic                                  o_job_valid,
    input  wire logic                             i_job_ready,
    output blfr_pkg::t_job                        o_job,
    input  wire logic                             i_release
);
    import blfr_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    logic [AW-1:0]          r_wpos;
    logic [FRAME_BYTES-1:0] r_written;
    logic                   r_busy;
    logic [BYTE_W-1:0]      r_adr, r_lenb, r_cmd;
    logic [BYTE_W-1:0]      n_adr, n_lenb, n_cmd;
    logic [AW-1:0]          wpos;
    logic                   accept;
    logic                   is_tail;
    logic [BYTE_W-1:0]      len;

    assign o_in_ready = !r_busy && i_job_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_tail    = (i_rx_byte == i_tail);
    assign wpos       = (i_rx_byte == i_head) ? '0 : r_wpos;

    assign o_we      = accept;
    assign o_waddr   = wpos;
    assign o_wdata   = i_rx_byte;
    assign o_written = r_written;

    // header fields as they stand after this byte is stored
    assign n_adr  = (wpos == AW'(POS_ADDR)) ? i_rx_byte : r_adr;
    assign n_lenb = (wpos == AW'(POS_LEN))  ? i_rx_byte : r_lenb;
    assign n_cmd  = (wpos == AW'(POS_CMD))  ? i_rx_byte : r_cmd;

    // tens digit times ten plus units digit
    assign len = {1'b0, n_lenb[7:4], 3'b000} + {3'b000, n_lenb[7:4], 1'b0}
               + {4'b0000, n_lenb[3:0]};

    assign o_job_valid   = accept && is_tail;
    assign o_job.adr     = n_adr;
    assign o_job.lenb    = n_lenb;
    assign o_job.cmd     = n_cmd;
    assign o_job.len     = len;
    assign o_job.bad_len = (len == '0)
                        || ((9'(len) + 9'(POS_INFO)) > 9'(FRAME_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos    <= '0;
            r_written <= '0;
            r_busy    <= 1'b0;
            r_adr     <= '0;
            r_lenb    <= '0;
            r_cmd     <= '0;
        end else begin
            if (accept) begin
                r_wpos <= (wpos == AW'(FRAME_BYTES - 1)) ? '0 : wpos + 1'b1;
                r_written[wpos] <= 1'b1;
                r_adr  <= n_adr;
                r_lenb <= n_lenb;
                r_cmd  <= n_cmd;
                if (is_tail) begin
                    r_busy <= 1'b1;
                end
            end else if (i_release) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/blfr_fifo.sv
// blfr_fifo: two-entry queue of check jobs between front and back
// depends on blfr_pkg
`default_nettype none

module blfr_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_ready,
    input  wire blfr_pkg::t_job i_job,
    output logic                o_valid,
    input  wire logic           i_pop,
    output blfr_pkg::t_job      o_job
);
    import blfr_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/blfr_back.sv
// blfr_back: checks a queued frame against the store and emits its results
// depends on blfr_pkg
`default_nettype none

module blfr_back #(
    parameter int FRAME_BYTES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_job_valid,
    output logic                               o_job_pop,
    input  wire blfr_pkg::t_job                i_job,
    input  wire logic [blfr_pkg::BYTE_W-1:0]   i_host,
    input  wire logic [blfr_pkg::BYTE_W-1:0]   i_bcast,
    output logic                               o_re,
    output logic [$clog2(FRAME_BYTES)-1:0]     o_raddr,
    input  wire logic [blfr_pkg::BYTE_W-1:0]   i_rdata,
    input  wire logic [FRAME_BYTES-1:0]        i_written,
    output logic                               o_release,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [blfr_pkg::STATUS_W-1:0]      o_status,
    output logic [blfr_pkg::BYTE_W-1:0]        o_command,
    output logic [blfr_pkg::BYTE_W-1:0]        o_address,
    output logic [blfr_pkg::BYTE_W-1:0]        o_data_byte,
    output logic                               o_data_valid,
    output logic [blfr_pkg::IDX_W-1:0]         o_byte_index,
    output logic                               o_last
);
    import blfr_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_SUM     = 3'd2;
    localparam logic [2:0] S_SUMW    = 3'd3;
    localparam logic [2:0] S_STATUS  = 3'd4;
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT_WR = 3'd6;

    logic [2:0]          r_state;
    t_job                r_job;
    logic [AW-1:0]       r_addr;
    logic [BYTE_W-1:0]   r_sum;
    logic                r_pend;
    logic                r_rd_ok;
    logic [STATUS_W-1:0] r_status;

    logic [AW-1:0]       chk_addr;
    logic [AW-1:0]       last_info;
    logic [BYTE_W-1:0]   rdata;
    logic                slot_free;
    logic                addr_ok;
    logic                out_load;

    assign chk_addr  = AW'(POS_CMD) + AW'(r_job.len);
    assign last_info = chk_addr - 1'b1;
    assign rdata     = r_rd_ok ? i_rdata : '0;
    assign slot_free = !o_out_valid || i_out_ready;
    assign addr_ok   = (r_job.adr == i_host) || (r_job.adr == i_bcast);

    // a new result enters the output register this cycle
    assign out_load  = slot_free && ((r_state == S_STATUS) || (r_state == S_EMIT_WR));

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_re      = (r_state == S_SUM) || (r_state == S_EMIT_RD);
    assign o_raddr   = r_addr;
    assign o_release = ((r_state == S_STATUS) && slot_free)
                    || ((r_state == S_EMIT_WR) && slot_free && (r_addr == last_info));

    // store entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (o_re) begin
            r_rd_ok <= i_written[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == S_SUM) && (r_addr != chk_addr);
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_sum  <= r_job.adr + r_job.lenb + r_job.cmd;
                    r_addr <= AW'(POS_INFO);
                    if (r_job.bad_len) begin
                        r_status <= ST_BAD_LEN;
                        r_state  <= S_STATUS;
                    end else if (!addr_ok) begin
                        r_status <= ST_ADDR;
                        r_state  <= S_STATUS;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // info reads run straight into the checksum position
                    if (r_pend) begin
                        r_sum <= r_sum + rdata;
                    end
                    if (r_addr == chk_addr) begin
                        r_state <= S_SUMW;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_SUMW: begin
                    r_addr <= AW'(POS_INFO);
                    if (bcd8(r_sum) != rdata) begin
                        r_status <= ST_CHKSUM;
                        r_state  <= S_STATUS;
                    end else if (r_job.len == 8'd1) begin
                        r_status <= ST_ACCEPT;
                        r_state  <= S_STATUS;
                    end else begin
                        r_state <= S_EMIT_RD;
                    end
                end
                S_STATUS: begin
                    if (slot_free) begin
                        o_status     <= r_status;
                        o_command    <= r_job.cmd;
                        o_address    <= r_job.adr;
                        o_data_byte  <= '0;
                        o_data_valid <= 1'b0;
                        o_byte_index <= '0;
                        o_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (slot_free) begin
                        o_status     <= ST_ACCEPT;
                        o_command    <= r_job.cmd;
                        o_address    <= r_job.adr;
                        o_data_byte  <= rdata;
                        o_data_valid <= 1'b1;
                        o_byte_index <= IDX_W'(r_addr - AW'(POS_INFO));
                        o_last       <= (r_addr == last_info);
                        if (r_addr == last_info) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= r_addr + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
